// ===== hdl/reverb_comb_chain_lowpass_macros.svh =====
// assertion macros for the comb chain reverb
// used by the top level; clock and reset are the names of the module that includes it
`ifndef REVERB_COMB_CHAIN_LOWPASS_MACROS_SVH
`define REVERB_COMB_CHAIN_LOWPASS_MACROS_SVH
`ifndef SYNTHESIS
`define RCL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define RCL_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define RCL_ASSERT(lbl, prop, msg)
`define RCL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/rcl_pkg.sv =====
// types, constants, microcode table and delay line sizing for the comb chain reverb
// no dependencies
`timescale 1ns / 1ps

package rcl_pkg;

   localparam int          CSR_IDX_W  = 2;
   localparam int          CSR_DATA_W = 16;
   localparam logic [15:0] Q_ONE      = 16'h8000;
   localparam int          ROUND_HALF = 16384;

   localparam logic [CSR_IDX_W-1:0] CSR_SEND_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_GAIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LP_ALPHA   = 2'd3;

   localparam logic [15:0] SEND_LEVEL_RST = 16'd32768;
   localparam logic [14:0] STAGE_GAIN_RST = 15'd22938;
   localparam logic [15:0] LAST_GAIN_RST  = 16'd32768;
   localparam logic [15:0] LP_ALPHA_RST   = 16'd32535;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_SEND,
      STEP_SCALE,
      STEP_MUL,
      STEP_WRITE,
      STEP_LP_B,
      STEP_LP_C
   } step_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SEND,
      MUL_DELAY,
      MUL_ALPHA,
      MUL_ONE_MINUS
   } mul_sel_type;

   typedef enum logic [1:0] {
      Y_HOLD,
      Y_LOAD,
      Y_SEND,
      Y_STAGE
   } y_sel_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CUR,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_REQ,
      COND_MORE,
      COND_SLOT
   } cond_type;

   typedef struct packed {
      logic        ready;
      logic        stage_clr;
      mul_sel_type mul_sel;
      y_sel_type   y_sel;
      rd_sel_type  rd_sel;
      logic        wr_en;
      logic        acc_load;
      logic        lp_done;
      cond_type    cond;
      step_type    target;
   } ctrl_word_type;

   localparam ctrl_word_type CTRL_NOP = '{
      ready:     1'b0,
      stage_clr: 1'b0,
      mul_sel:   MUL_NONE,
      y_sel:     Y_HOLD,
      rd_sel:    RD_NONE,
      wr_en:     1'b0,
      acc_load:  1'b0,
      lp_done:   1'b0,
      cond:      COND_NEXT,
      target:    STEP_IDLE
   };

   // control store
   function automatic ctrl_word_type ucode(input step_type s);
      ctrl_word_type w;
      w = CTRL_NOP;
      unique case (s)
         STEP_IDLE: begin
            w.ready     = 1'b1;
            w.stage_clr = 1'b1;
            w.y_sel     = Y_LOAD;
            w.cond      = COND_REQ;
         end
         STEP_SEND: begin
            w.mul_sel = MUL_SEND;
         end
         STEP_SCALE: begin
            w.y_sel  = Y_SEND;
            w.rd_sel = RD_CUR;
         end
         STEP_MUL: begin
            w.mul_sel = MUL_DELAY;
         end
         STEP_WRITE: begin
            w.y_sel   = Y_STAGE;
            w.rd_sel  = RD_NEXT;
            w.wr_en   = 1'b1;
            w.mul_sel = MUL_ALPHA;
            w.cond    = COND_MORE;
            w.target  = STEP_MUL;
         end
         STEP_LP_B: begin
            w.acc_load = 1'b1;
            w.mul_sel  = MUL_ONE_MINUS;
         end
         STEP_LP_C: begin
            w.lp_done = 1'b1;
            w.cond    = COND_SLOT;
            w.target  = STEP_IDLE;
         end
         default: begin
            w = CTRL_NOP;
         end
      endcase
      return w;
   endfunction

   function automatic logic [15:0] clamp_q(input logic [15:0] v);
      return (v > Q_ONE) ? Q_ONE : v;
   endfunction

   // quotient by shift and subtract, for elaboration constants only
   function automatic longint unsigned div_floor(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // floor(base * 1.05^stage), exact in integers
   function automatic longint unsigned line_len(input longint unsigned base_delay,
                                                input int unsigned stage);
      longint unsigned num;
      longint unsigned den;
      num = base_delay;
      den = 1;
      for (int unsigned i = 0; i < stage; i++) begin
         num = num * 105;
         den = den * 100;
      end
      return div_floor(num, den);
   endfunction

   function automatic longint unsigned line_off(input longint unsigned base_delay,
                                                input int unsigned stage);
      longint unsigned off;
      off = 0;
      for (int unsigned i = 0; i < stage; i++) begin
         off = off + line_len(base_delay, i);
      end
      return off;
   endfunction

endpackage

// ===== hdl/rcl_req_if.sv =====
// input sample channel: valid/ready with sample and channel bit
// depends on nothing
`timescale 1ns / 1ps

interface rcl_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic                           channel;

   modport source (output valid, output sample_in, output channel, input ready);
   modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

// ===== hdl/rcl_rsp_if.sv =====
// result channel: valid/ready with the output sample
// depends on nothing
`timescale 1ns / 1ps

interface rcl_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hdl/rcl_csr_if.sv =====
// register write channel: valid/ready with index and data
// depends on rcl_pkg
`timescale 1ns / 1ps

interface rcl_csr_if
   import rcl_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rcl_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/reverb_comb_chain_lowpass.sv =====
// comb chain reverb with per-channel one-pole lowpass, microcoded over one multiplier
// a new input beat is taken only in the idle step, so the shared multiplier and the delay
//   ram, which take a read-multiply-write per stage, finish one beat before the next is taken;
//   the last step waits while the result slot is full
// reset: synchronous; settings reload, pointers and lowpass memories clear at once, delay lines
//   read as zero until each stage's first pass completes, so no clearing sweep is needed
`timescale 1ns / 1ps
`include "reverb_comb_chain_lowpass_macros.svh"

module reverb_comb_chain_lowpass
   import rcl_pkg::*;
#(
   parameter int NUM_STAGES   = 5,
   parameter int BASE_DELAY   = 4096,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rcl_req_if.sink   req_bus,
   rcl_rsp_if.source rsp_bus,
   rcl_csr_if.sink   csr_bus
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int PW      = SW + 17;
   localparam int SUM_W   = SW + 3;
   localparam int STAGE_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam longint unsigned MAX_LEN =
      line_len(longint'(BASE_DELAY), NUM_STAGES - 1);
   localparam longint unsigned TOTAL_LEN =
      line_off(longint'(BASE_DELAY), NUM_STAGES);
   localparam int PTR_W     = $clog2(MAX_LEN);
   localparam int AW        = $clog2(TOTAL_LEN);
   localparam int MEM_DEPTH = int'(TOTAL_LEN);

   function automatic logic signed [SW-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [SW-1:0] r;
      if (v[SUM_W-1:SW-1] == {4{v[SW-1]}}) begin
         r = v[SW-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(SW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SW-1){1'b1}}};
      end
      return r;
   endfunction

   // stage geometry
   logic [PTR_W-1:0] stage_last [NUM_STAGES];
   logic [AW-1:0]    stage_off  [NUM_STAGES];

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_geom
      assign stage_last[g] = PTR_W'(line_len(longint'(BASE_DELAY), g) - 1);
      assign stage_off[g]  = AW'(line_off(longint'(BASE_DELAY), g));
   end

   // registers
   logic [15:0]            send_level_ff, send_level_in;
   logic [14:0]            stage_gain_ff, stage_gain_in;
   logic [15:0]            last_gain_ff, last_gain_in;
   logic [15:0]            lp_alpha_ff, lp_alpha_in;
   step_type               step_ff, step_in;
   logic [STAGE_W-1:0]     stage_ff, stage_in;
   logic [PTR_W-1:0]       ptr_ff [NUM_STAGES];
   logic [PTR_W-1:0]       ptr_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]  lap_ff, lap_in;
   logic signed [SW-1:0]   lp_mem_ff [2];
   logic signed [SW-1:0]   lp_mem_in [2];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]   rsp_data_ff, rsp_data_in;
   logic signed [SW-1:0]   y_ff, y_in;
   logic                   ch_ff, ch_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [PW-1:0]   acc_ff, acc_in;

   // datapath signals
   ctrl_word_type          cw;
   logic                   accept;
   logic                   slot_free;
   logic                   last;
   logic [STAGE_W-1:0]     rd_stage;
   logic                   ram_rd_en;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [AW-1:0]          ram_wr_addr;
   logic [SW-1:0]          ram_rd_data;
   logic signed [SW-1:0]   delay_val;
   logic signed [SW-1:0]   mul_a;
   logic [15:0]            mul_b;
   logic signed [PW-1:0]   mul_p;
   logic signed [PW-1:0]   prod_bias;
   logic signed [PW-16:0]  prod_rnd;
   logic signed [SUM_W-1:0] stage_sum;
   logic signed [SW-1:0]   send_sat;
   logic signed [SW-1:0]   stage_sat;
   logic signed [PW:0]     acc_sum;
   logic signed [PW:0]     acc_bias;
   logic signed [SUM_W-1:0] lp_rnd;
   logic signed [SW-1:0]   lp_sat;

   assign cw        = ucode(step_ff);
   assign accept    = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign last      = (stage_ff == STAGE_W'(NUM_STAGES - 1));

   assign req_bus.ready      = cw.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_data_ff;
   assign csr_bus.ready      = 1'b1;

   // register writes
   always_comb begin
      send_level_in = send_level_ff;
      stage_gain_in = stage_gain_ff;
      last_gain_in  = last_gain_ff;
      lp_alpha_in   = lp_alpha_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SEND_LEVEL: send_level_in = clamp_q(csr_bus.data);
            CSR_STAGE_GAIN: stage_gain_in = csr_bus.data[14:0];
            CSR_LAST_GAIN:  last_gain_in  = clamp_q(csr_bus.data);
            CSR_LP_ALPHA:   lp_alpha_in   = clamp_q(csr_bus.data);
         endcase
      end
   end

   // sequencer next step
   always_comb begin
      step_in = step_ff;
      unique case (cw.cond)
         COND_NEXT: step_in = step_type'(step_ff + 3'd1);
         COND_REQ: begin
            if (accept) begin
               step_in = step_type'(step_ff + 3'd1);
            end
         end
         COND_MORE: step_in = last ? step_type'(step_ff + 3'd1) : cw.target;
         COND_SLOT: begin
            if (slot_free) begin
               step_in = cw.target;
            end
         end
      endcase
   end

   // delay ram addressing
   always_comb begin
      rd_stage  = stage_ff;
      ram_rd_en = 1'b0;
      case (cw.rd_sel)
         RD_CUR: ram_rd_en = 1'b1;
         RD_NEXT: begin
            ram_rd_en = !last;
            if (!last) begin
               rd_stage = STAGE_W'(stage_ff + 1'b1);
            end
         end
         default: ram_rd_en = 1'b0;
      endcase
   end

   assign ram_rd_addr = stage_off[rd_stage] + AW'(ptr_ff[rd_stage]);
   assign ram_wr_addr = stage_off[stage_ff] + AW'(ptr_ff[stage_ff]);
   assign ram_wr_en   = cw.wr_en;

   rcl_ram #(
      .WIDTH (SW),
      .DEPTH (MEM_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (stage_sat),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // unwritten entries of a line read as zero until its first lap is done
   assign delay_val = lap_ff[stage_ff] ? $signed(ram_rd_data) : '0;

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cw.mul_sel)
         MUL_SEND: begin
            mul_a = y_ff;
            mul_b = send_level_ff;
         end
         MUL_DELAY: begin
            mul_a = delay_val;
            mul_b = last ? last_gain_ff : {1'b0, stage_gain_ff};
         end
         MUL_ALPHA: begin
            mul_a = lp_mem_ff[ch_ff];
            mul_b = lp_alpha_ff;
         end
         MUL_ONE_MINUS: begin
            mul_a = y_ff;
            mul_b = Q_ONE - lp_alpha_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * $signed({1'b0, mul_b});

   // rounding and saturation
   assign prod_bias = prod_ff + PW'(ROUND_HALF);
   assign prod_rnd  = prod_bias[PW-1:15];
   assign send_sat  = sat(SUM_W'(prod_rnd));
   assign stage_sum = SUM_W'(y_ff) + SUM_W'(prod_rnd);
   assign stage_sat = sat(stage_sum);
   assign acc_sum   = (PW+1)'(acc_ff) + (PW+1)'(prod_ff);
   assign acc_bias  = acc_sum + (PW+1)'(ROUND_HALF);
   assign lp_rnd    = acc_bias[PW:15];
   assign lp_sat    = sat(lp_rnd);

   // datapath next values
   always_comb begin
      y_in         = y_ff;
      ch_in        = ch_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      stage_in     = stage_ff;
      ptr_in       = ptr_ff;
      lap_in       = lap_ff;
      lp_mem_in    = lp_mem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      case (cw.y_sel)
         Y_LOAD: begin
            if (accept) begin
               y_in  = req_bus.sample_in;
               ch_in = req_bus.channel;
            end
         end
         Y_SEND:  y_in = send_sat;
         Y_STAGE: y_in = stage_sat;
         default: y_in = y_ff;
      endcase

      if (cw.mul_sel != MUL_NONE) begin
         prod_in = mul_p;
      end
      if (cw.acc_load) begin
         acc_in = prod_ff;
      end

      if (cw.stage_clr) begin
         stage_in = '0;
      end else if (cw.wr_en && !last) begin
         stage_in = STAGE_W'(stage_ff + 1'b1);
      end

      if (cw.wr_en) begin
         if (ptr_ff[stage_ff] == stage_last[stage_ff]) begin
            ptr_in[stage_ff] = '0;
            lap_in[stage_ff] = 1'b1;
         end else begin
            ptr_in[stage_ff] = PTR_W'(ptr_ff[stage_ff] + 1'b1);
         end
      end

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cw.lp_done && slot_free) begin
         lp_mem_in[ch_ff] = lp_sat;
         rsp_valid_in     = 1'b1;
         rsp_data_in      = lp_sat;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         send_level_ff <= SEND_LEVEL_RST;
         stage_gain_ff <= STAGE_GAIN_RST;
         last_gain_ff  <= LAST_GAIN_RST;
         lp_alpha_ff   <= LP_ALPHA_RST;
         step_ff       <= STEP_IDLE;
         stage_ff      <= '0;
         lap_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_STAGES; i++) begin
            ptr_ff[i] <= '0;
         end
         lp_mem_ff[0] <= '0;
         lp_mem_ff[1] <= '0;
      end else begin
         send_level_ff <= send_level_in;
         stage_gain_ff <= stage_gain_in;
         last_gain_ff  <= last_gain_in;
         lp_alpha_ff   <= lp_alpha_in;
         step_ff       <= step_in;
         stage_ff      <= stage_in;
         lap_ff        <= lap_in;
         rsp_valid_ff  <= rsp_valid_in;
         ptr_ff        <= ptr_in;
         lp_mem_ff     <= lp_mem_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      ch_ff       <= ch_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   `RCL_ASSERT_NEXT(a_beat_starts_program, req_bus.valid && req_bus.ready, step_ff == STEP_SEND, "input beat did not start the program")
   `RCL_ASSERT(a_stage_in_range, stage_ff <= STAGE_W'(NUM_STAGES - 1), "stage counter out of range")
   `RCL_ASSERT(a_ptr_in_range, ptr_ff[stage_ff] <= stage_last[stage_ff], "line pointer past its length")
   `RCL_ASSERT_NEXT(a_result_waits, step_ff == STEP_LP_C && rsp_valid_ff && !rsp_bus.ready, step_ff == STEP_LP_C && rsp_valid_ff, "result step moved while output slot busy")

endmodule

// ===== tb/reverb_comb_chain_lowpass_tb.sv =====
// self-checking testbench for the comb chain reverb with per-channel lowpass
// drives reverb_comb_chain_lowpass through rcl_req_if, rcl_rsp_if and rcl_csr_if, with constants from rcl_pkg
`timescale 1ns / 1ps

module reverb_comb_chain_lowpass_tb;
   import rcl_pkg::*;

   localparam int NUM_STAGES     = 5;
   localparam int BASE_DELAY     = 4096;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COMB_SPAN      = NUM_STAGES * BASE_DELAY * 2;
   localparam int PHASE_SAMPLES  = 198;
   localparam int RANDOM_PHASES  = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic signed [15:0] sample;
      logic               ch;
   } sample_beat_type;

   logic clock;
   logic reset;

   rcl_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_bus ();
   rcl_rsp_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) rsp_bus ();
   rcl_csr_if csr_bus ();

   reverb_comb_chain_lowpass #(
      .NUM_STAGES  (NUM_STAGES),
      .BASE_DELAY  (BASE_DELAY),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // predictor state
   logic [15:0]        send_lvl;
   logic [14:0]        stage_g;
   logic [15:0]        last_g;
   logic [15:0]        lp_alpha;
   logic signed [15:0] comb_mem [COMB_SPAN];
   int unsigned        tap_len  [NUM_STAGES];
   int unsigned        tap_base [NUM_STAGES];
   int unsigned        tap_ptr  [NUM_STAGES];
   logic signed [15:0] lp_mem   [2];

   sample_beat_type    send_queue[$];
   logic signed [15:0] wet_expected[$];

   logic        req_beat;
   logic        rsp_beat;
   logic        req_quiet;
   logic        rsp_quiet;
   int unsigned req_gap;
   int unsigned rsp_wait;
   int          stall_cycles   = 0;
   int          mismatch_count = 0;
   int          checked_count  = 0;
   int          sample_count   = 0;
   int          setting_count  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_q15(input longint v);
      return (v + ROUND_HALF) >>> 15;
   endfunction

   function automatic longint clip_sample(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic logic [15:0] clamp_unity(input logic [15:0] v);
      return (v > 16'd32768) ? 16'd32768 : v;
   endfunction

   function automatic int unsigned comb_length(input int unsigned stage);
      longint unsigned num;
      longint unsigned den;
      num = BASE_DELAY;
      den = 1;
      for (int unsigned i = 0; i < stage; i++) begin
         num = num * 105;
         den = den * 100;
      end
      return int'(num / den);
   endfunction

   // send scale, comb chain, then per-channel one-pole lowpass
   function automatic logic signed [15:0] reverb_predict(input logic signed [15:0] smp,
                                                          input logic ch);
      longint y;
      longint d;
      longint g;
      longint acc;
      int unsigned pos;
      y = clip_sample(round_q15(longint'(smp) * longint'(send_lvl)));
      for (int s = 0; s < NUM_STAGES; s++) begin
         g = (s == NUM_STAGES - 1) ? longint'(last_g) : longint'(stage_g);
         pos = tap_base[s] + tap_ptr[s];
         d = comb_mem[pos];
         y = clip_sample(y + round_q15(d * g));
         comb_mem[pos] = y[15:0];
         tap_ptr[s] = (tap_ptr[s] + 1 >= tap_len[s]) ? 0 : tap_ptr[s] + 1;
      end
      acc = longint'(lp_alpha) * longint'(lp_mem[ch])
          + (longint'(32768) - longint'(lp_alpha)) * y;
      y = clip_sample(round_q15(acc));
      lp_mem[ch] = y[15:0];
      return y[15:0];
   endfunction

   function automatic logic signed [15:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 255)) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] draw_level();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32768));
   endfunction

   function void push_sample(input logic signed [15:0] s, input logic ch);
      sample_beat_type b;
      b.sample = s;
      b.ch     = ch;
      send_queue.push_back(b);
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_setting(input logic [15:0] send, input logic [15:0] stage,
                               input logic [15:0] last, input logic [15:0] alpha);
      csr_write(CSR_SEND_LEVEL, send);
      csr_write(CSR_STAGE_GAIN, stage);
      csr_write(CSR_LAST_GAIN, last);
      csr_write(CSR_LP_ALPHA, alpha);
      setting_count++;
   endtask

   task automatic settle_block();
      while (send_queue.size() != 0 || req_bus.valid || wet_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // input driver
   always @(negedge clock) begin : req_drive
      sample_beat_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else if (req_bus.valid && !req_beat) begin
         // holding the beat
      end else if (req_gap != 0) begin
         req_bus.valid <= 1'b0;
         req_gap       <= req_gap - 1;
      end else if (send_queue.size() != 0) begin
         nxt = send_queue.pop_front();
         req_bus.sample_in <= nxt.sample;
         req_bus.channel   <= nxt.ch;
         req_bus.valid     <= 1'b1;
         req_gap           <= req_quiet ? 0 : $urandom_range(0, 15);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin : rsp_drive
      int unsigned n;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait      <= 0;
      end else if (rsp_beat) begin
         n = rsp_quiet ? 0 : $urandom_range(0, 15);
         rsp_wait      <= n;
         rsp_bus.ready <= (n == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait      <= rsp_wait - 1;
         rsp_bus.ready <= (rsp_wait == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: predict on accepted samples, check accepted results, track register writes
   always @(posedge clock) begin : monitor
      logic signed [15:0] want;
      logic               any_beat;
      if (reset) begin
         req_beat     <= 1'b0;
         rsp_beat     <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_beat <= req_bus.valid && req_bus.ready;
         rsp_beat <= rsp_bus.valid && rsp_bus.ready;
         any_beat = (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                 || (csr_bus.valid && csr_bus.ready);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (wet_expected.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %0d",
                        $time, rsp_bus.sample_out);
               mismatch_count++;
            end else begin
               want = wet_expected.pop_front();
               checked_count++;
               if (rsp_bus.sample_out !== want) begin
                  $display("%0t: sample_out mismatch, expected %0d actual %0d",
                           $time, want, rsp_bus.sample_out);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            wet_expected.push_back(reverb_predict(req_bus.sample_in, req_bus.channel));
            sample_count++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_SEND_LEVEL: send_lvl = clamp_unity(csr_bus.data);
               CSR_STAGE_GAIN: stage_g  = csr_bus.data[14:0];
               CSR_LAST_GAIN:  last_g   = clamp_unity(csr_bus.data);
               CSR_LP_ALPHA:   lp_alpha = clamp_unity(csr_bus.data);
               default: ;
            endcase
         end
         stall_cycles <= any_beat ? 0 : stall_cycles + 1;
      end
   end

   initial begin : watchdog
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL reverb_comb_chain_lowpass");
      $finish;
   end

   initial begin : stimulus
      int unsigned        off;
      logic               prev_ch;
      logic               ch;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      req_bus.channel   = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      req_quiet         = 1'b0;
      rsp_quiet         = 1'b0;
      send_lvl          = SEND_LEVEL_RST;
      stage_g           = STAGE_GAIN_RST;
      last_g            = LAST_GAIN_RST;
      lp_alpha          = LP_ALPHA_RST;
      lp_mem[0]         = '0;
      lp_mem[1]         = '0;
      foreach (comb_mem[i]) comb_mem[i] = '0;
      off = 0;
      for (int s = 0; s < NUM_STAGES; s++) begin
         tap_len[s]  = comb_length(s);
         tap_base[s] = off;
         tap_ptr[s]  = 0;
         off += tap_len[s];
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes on both channels
      req_quiet = $urandom_range(0, 1);
      rsp_quiet = $urandom_range(0, 1);
      push_sample(16'sh7fff, 1'b0);
      push_sample(16'sh7fff, 1'b1);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sh8000, 1'b1);
      push_sample(16'sh0000, 1'b0);
      push_sample(16'sh0001, 1'b1);
      push_sample(16'shffff, 1'b0);
      push_sample(16'sh5555, 1'b1);
      push_sample(16'shaaaa, 1'b0);
      push_sample(16'sh0000, 1'b1);
      settle_block();

      // oversized levels clamp to unity, stage gain top bit dropped
      load_setting(16'hffff, 16'hffff, 16'h8001, 16'h0000);
      push_sample(16'sh7fff, 1'b0);
      push_sample(16'sh8000, 1'b1);
      push_sample(16'sh3039, 1'b0);
      push_sample(16'shcfc7, 1'b1);
      push_sample(16'sh0001, 1'b0);
      push_sample(16'shffff, 1'b1);
      settle_block();

      // all-zero gains, alpha at unity
      load_setting(16'h0000, 16'h0000, 16'h0000, Q_ONE);
      push_sample(16'sh7fff, 1'b0);
      push_sample(16'sh8000, 1'b1);
      push_sample(16'sh7fff, 1'b1);
      push_sample(16'sh8000, 1'b0);
      settle_block();

      // random: interleaved stereo under reset, extreme, zero and drawn settings
      prev_ch = 1'b1;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: load_setting(SEND_LEVEL_RST, {1'b0, STAGE_GAIN_RST}, LAST_GAIN_RST,
                            LP_ALPHA_RST);
            2, 5: load_setting(Q_ONE, 16'h7fff, Q_ONE, 16'h0000);
            6: load_setting(16'h0000, 16'h0000, 16'h0000, Q_ONE);
            default: load_setting(draw_level(), 16'($urandom), draw_level(), draw_level());
         endcase
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_SAMPLES; k++) begin
            ch = ($urandom_range(0, 9) == 0) ? 1'($urandom) : ~prev_ch;
            prev_ch = ch;
            push_sample(draw_sample(), ch);
         end
         settle_block();
      end

      $display("checked %0d results from %0d stereo samples over %0d register settings",
               checked_count, sample_count, setting_count + 1);
      $display("comb lines exercised under max, zero and random gains; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && wet_expected.size() == 0) begin
         $display("PASS reverb_comb_chain_lowpass");
      end else begin
         $display("FAIL reverb_comb_chain_lowpass");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rcl_pkg.sv
hdl/rcl_req_if.sv
hdl/rcl_rsp_if.sv
hdl/rcl_csr_if.sv
hdl/rcl_ram.sv
hdl/reverb_comb_chain_lowpass.sv
tb/reverb_comb_chain_lowpass_tb.sv
